// ===== design/csev_pkg.sv =====
package csev_pkg;

    localparam int POINT_W   = 16;
    localparam int TIME_W    = 24;
    localparam int AXIS_W    = 2;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int COUNT_W   = 3;

    // Register map of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_BASE  = 3'd1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd4;
    localparam logic [COUNT_W-1:0] COUNT_MIN   = 3'd4;

    // 1.0 in unsigned Q8.16.
    localparam logic [TIME_W-1:0] TIME_ONE = 24'h010000;

    // Coefficient and Horner accumulator widths.
    localparam int COEF_W = 20;
    localparam int ACC_W  = 40;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified sample: the four points of its segment, the local
    // fraction, the tension select and the axis tag.
    typedef struct packed {
        logic signed [POINT_W-1:0] p0;
        logic signed [POINT_W-1:0] p1;
        logic signed [POINT_W-1:0] p2;
        logic signed [POINT_W-1:0] p3;
        logic        [FRAC_W-1:0]  u;
        logic                      tense;
        logic        [AXIS_W-1:0]  axis;
    } csev_item_t;

endpackage

// ===== design/csev_front.sv =====
module csev_front #(
    parameter int MAX_POINTS = 7
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [csev_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [csev_pkg::POINT_W-1:0]       cfg_data,
    input  logic [csev_pkg::TIME_W-1:0]        time_value,
    input  logic [csev_pkg::AXIS_W-1:0]        axis,
    output csev_pkg::csev_item_t               item
);

    logic [csev_pkg::COUNT_W-1:0]       count_reg;
    logic signed [csev_pkg::POINT_W-1:0] points_reg [MAX_POINTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= csev_pkg::COUNT_RESET;
            for (int j = 0; j < MAX_POINTS; j++)
            begin
                points_reg[j] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            if (cfg_index == csev_pkg::REG_POINT_COUNT)
            begin
                count_reg <= cfg_data[csev_pkg::COUNT_W-1:0];
            end
            // Points beyond the stored range are never read, so their
            // writes are dropped.
            for (int j = 0; j < MAX_POINTS; j++)
            begin
                if (cfg_index == csev_pkg::REG_POINT_BASE + csev_pkg::CFG_IDX_W'(j))
                begin
                    points_reg[j] <= cfg_data;
                end
            end
        end
    end

    logic [csev_pkg::COUNT_W-1:0] n_eff;
    logic [16:0]                  t_clamped;
    logic [19:0]                  scaled;
    logic [2:0]                   k;
    logic [3:0]                   i1;
    logic [3:0]                   i2;
    logic [3:0]                   i3;
    logic [3:0]                   last;

    always_comb
    begin
        priority if (count_reg < csev_pkg::COUNT_MIN)
        begin
            n_eff = csev_pkg::COUNT_MIN;
        end
        else if (count_reg > csev_pkg::COUNT_W'(MAX_POINTS))
        begin
            n_eff = csev_pkg::COUNT_W'(MAX_POINTS);
        end
        else
        begin
            n_eff = count_reg;
        end

        if (time_value > csev_pkg::TIME_ONE)
        begin
            t_clamped = 17'h10000;
        end
        else
        begin
            t_clamped = time_value[16:0];
        end

        // Segment count is n - 3; the integer part picks the segment.
        scaled = 20'(t_clamped) * 20'(n_eff - 3'd3);
        k      = scaled[18:16];

        last = {1'b0, n_eff} - 4'd1;
        i1   = {1'b0, k} + 4'd1;
        i2   = ({1'b0, k} + 4'd2 > last) ? last : {1'b0, k} + 4'd2;
        i3   = ({1'b0, k} + 4'd3 > last) ? last : {1'b0, k} + 4'd3;

        item.p0 = '0;
        item.p1 = '0;
        item.p2 = '0;
        item.p3 = '0;
        for (int j = 0; j < MAX_POINTS; j++)
        begin
            if ({1'b0, k} == 4'(j))
            begin
                item.p0 = points_reg[j];
            end
            if (i1 == 4'(j))
            begin
                item.p1 = points_reg[j];
            end
            if (i2 == 4'(j))
            begin
                item.p2 = points_reg[j];
            end
            if (i3 == 4'(j))
            begin
                item.p3 = points_reg[j];
            end
        end

        item.u     = scaled[15:0];
        // The first segment, and the end case t = 1.0, use zero tangents.
        item.tense = (i1 >= 4'd2) && (i1 + 4'd2 < {1'b0, n_eff});
        item.axis  = axis;
    end

endmodule

// ===== design/csev_queue.sv =====
module csev_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  csev_pkg::csev_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output csev_pkg::csev_item_t pop_item
);

    csev_pkg::csev_item_t              mem_reg [csev_pkg::QUEUE_DEPTH];
    logic [csev_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [csev_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [csev_pkg::QCNT_W-1:0]       count_reg;
    logic [csev_pkg::QCNT_W-1:0]       count_next;

    assign full      = (count_reg == csev_pkg::QCNT_W'(csev_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= csev_pkg::QCNT_W'(csev_pkg::QUEUE_DEPTH))
        else $error("queue fill count above depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue popped while empty");

endmodule

// ===== design/csev_back.sv =====
module csev_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_not_empty,
    input  csev_pkg::csev_item_t                q_item,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [csev_pkg::POINT_W-1:0] coordinate,
    output logic [csev_pkg::AXIS_W-1:0]         result_axis
);

    localparam int CW = csev_pkg::COEF_W;
    localparam int HW = csev_pkg::ACC_W;
    localparam int FW = csev_pkg::FRAC_W;
    localparam int AW = csev_pkg::AXIS_W;
    localparam int PW = csev_pkg::POINT_W;

    // One Horner step: floor((h * u + 2^15) / 2^16) + c * 2^16, with h split
    // into its upper part and its low 16 bits so both products stay narrow.
    function automatic logic signed [HW-1:0] horner_step(
        input logic signed [HW-1:0] h,
        input logic [FW-1:0]        u,
        input logic signed [CW-1:0] c
    );
        logic signed [HW-FW-1:0] hi;
        logic signed [HW:0]      prod_hi;
        logic [2*FW:0]           prod_lo;
        logic [FW:0]             rnd;
        hi      = h[HW-1:FW];
        prod_hi = hi * $signed({1'b0, u});
        prod_lo = (2*FW+1)'(h[FW-1:0] * u) + (2*FW+1)'(32768);
        rnd     = prod_lo[2*FW:FW];
        return prod_hi[HW-1:0] + HW'(rnd)
             + {{(HW-CW-FW){c[CW-1]}}, c, {FW{1'b0}}};
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;

    logic advance;
    assign advance = !out_valid_reg || out_ready;
    assign q_pop   = advance && q_not_empty;

    // Stage 1: tangent coefficients.
    logic signed [CW-1:0] a0_next, a1_next, a2_next, a3_next;
    logic signed [CW-1:0] x0, x1, x2, x3, d21;
    logic signed [CW-1:0] s1_a0_reg, s1_a1_reg, s1_a2_reg, s1_a3_reg;
    logic [FW-1:0]        s1_u_reg;
    logic [AW-1:0]        s1_axis_reg;

    always_comb
    begin
        x0  = CW'(q_item.p0);
        x1  = CW'(q_item.p1);
        x2  = CW'(q_item.p2);
        x3  = CW'(q_item.p3);
        d21 = x2 - x1;
        if (q_item.tense)
        begin
            a0_next = x3 - x0 + (x1 <<< 1) + x1 - (x2 <<< 1) - x2;
            a1_next = (x0 <<< 1) - (x1 <<< 2) - x1 + (x2 <<< 2) - x3;
            a2_next = x2 - x0;
        end
        else
        begin
            a0_next = -(d21 <<< 2);
            a1_next = (d21 <<< 2) + (d21 <<< 1);
            a2_next = '0;
        end
        a3_next = x1 <<< 1;
    end

    // Stage 2: h1 = A0 * u + A1 * 2^16.
    logic signed [CW+FW:0] prod1;
    logic signed [HW-1:0]  h1_next;
    logic signed [HW-1:0]  s2_h_reg;
    logic signed [CW-1:0]  s2_a2_reg, s2_a3_reg;
    logic [FW-1:0]         s2_u_reg;
    logic [AW-1:0]         s2_axis_reg;

    always_comb
    begin
        prod1   = s1_a0_reg * $signed({1'b0, s1_u_reg});
        h1_next = HW'(prod1)
                + {{(HW-CW-FW){s1_a1_reg[CW-1]}}, s1_a1_reg, {FW{1'b0}}};
    end

    // Stages 3 and 4: the remaining Horner steps.
    logic signed [HW-1:0] s3_h_reg;
    logic signed [CW-1:0] s3_a3_reg;
    logic [FW-1:0]        s3_u_reg;
    logic [AW-1:0]        s3_axis_reg;
    logic signed [HW-1:0] s4_h_reg;
    logic [AW-1:0]        s4_axis_reg;

    // Output: round half up to Q12.4 and saturate.
    logic signed [HW-1:0] biased;
    logic signed [HW-18:0] rounded;
    logic signed [PW-1:0] coord_next;
    logic signed [PW-1:0] coordinate_reg;
    logic [AW-1:0]        result_axis_reg;

    always_comb
    begin
        biased  = s4_h_reg + HW'(65536);
        rounded = biased[HW-1:17];
        priority if (rounded > (HW-17)'(32767))
        begin
            coord_next = 16'sh7fff;
        end
        else if (rounded < -(HW-17)'(32768))
        begin
            coord_next = 16'sh8000;
        end
        else
        begin
            coord_next = rounded[PW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= q_pop;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_a0_reg       <= a0_next;
            s1_a1_reg       <= a1_next;
            s1_a2_reg       <= a2_next;
            s1_a3_reg       <= a3_next;
            s1_u_reg        <= q_item.u;
            s1_axis_reg     <= q_item.axis;

            s2_h_reg        <= h1_next;
            s2_a2_reg       <= s1_a2_reg;
            s2_a3_reg       <= s1_a3_reg;
            s2_u_reg        <= s1_u_reg;
            s2_axis_reg     <= s1_axis_reg;

            s3_h_reg        <= horner_step(s2_h_reg, s2_u_reg, s2_a2_reg);
            s3_a3_reg       <= s2_a3_reg;
            s3_u_reg        <= s2_u_reg;
            s3_axis_reg     <= s2_axis_reg;

            s4_h_reg        <= horner_step(s3_h_reg, s3_u_reg, s3_a3_reg);
            s4_axis_reg     <= s3_axis_reg;

            coordinate_reg  <= coord_next;
            result_axis_reg <= s4_axis_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign coordinate  = coordinate_reg;
    assign result_axis = result_axis_reg;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable({v1_reg, v2_reg, v3_reg, v4_reg}))
        else $error("pipeline moved while output stalled");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(v4_reg))
        else $error("result appeared without a sample in the last stage");

endmodule

// ===== design/cardinal_spline_evaluator.sv =====
// Channel   | Handshake            | Payload
// ----------+----------------------+-----------------------------------------
// input     | in_valid / in_ready  | time_value (Q8.16), axis
// result    | out_valid / out_ready| coordinate (Q12.4), result_axis
// config    | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One sample is taken per cycle while the queue is not full; after its
// transfer it passes through the queue and then the arithmetic pipeline.
// The rate is set by the five-stage arithmetic pipeline (coefficients, three
// Horner steps, rounding), which advances every cycle the output register is
// free or being emptied.
// Reset clears the control state, sets the point count to four and all
// points to zero; no clearing pass is needed, so samples are taken at once.
// A stall on the result side freezes the pipeline; the four-entry queue keeps
// taking samples until it is full, then in_ready drops.
// The configuration port is always ready and takes effect on the next sample.
module cardinal_spline_evaluator #(
    parameter int MAX_POINTS = 7
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [csev_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csev_pkg::POINT_W-1:0]        cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [csev_pkg::TIME_W-1:0]         time_value,
    input  logic [csev_pkg::AXIS_W-1:0]         axis,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [csev_pkg::POINT_W-1:0] coordinate,
    output logic [csev_pkg::AXIS_W-1:0]         result_axis
);

    csev_pkg::csev_item_t front_item;
    csev_pkg::csev_item_t queue_item;
    logic                 queue_full;
    logic                 queue_not_empty;
    logic                 queue_pop;
    logic                 in_transfer;

    // Register writes are taken in any cycle.
    assign cfg_ready   = 1'b1;
    assign in_ready    = !queue_full;
    assign in_transfer = in_valid && in_ready;

    // The front clamps and scales the time, picks the segment's four points
    // and decides the tension; the classified sample goes straight into the
    // queue.
    csev_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .time_value (time_value),
        .axis       (axis),
        .item       (front_item)
    );

    // The queue decouples sample intake from the arithmetic pipeline.
    csev_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_transfer),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .pop_item  (queue_item)
    );

    // The back forms the cubic coefficients, runs the three Horner steps and
    // rounds and saturates into the output register.
    csev_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (queue_not_empty),
        .q_item      (queue_item),
        .q_pop       (queue_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .coordinate  (coordinate),
        .result_axis (result_axis)
    );

endmodule
